[rtl/core/mkde_pkg.sv]
// Shared types, codes and constants for the mixing key derivation engine.
package mkde_pkg;

    localparam int unsigned MAX_OUT_BYTES = 32;
    localparam int unsigned LEN_W         = 6;
    localparam int unsigned IDX_W         = 5;

    localparam logic [31:0] MIX_INIT   = 32'h6A09_E667;
    localparam logic [31:0] FNV_PRIME  = 32'h0100_0193;
    localparam logic [31:0] MURMUR_MUL = 32'h5BD1_E995;
    localparam logic [31:0] DERIVE_ADD = 32'd7;

    localparam logic [1:0] FUNC_KEY     = 2'd0;
    localparam logic [1:0] FUNC_CONTEXT = 2'd1;
    localparam logic [1:0] FUNC_FINISH  = 2'd2;

    localparam logic [1:0] CFG_OUTPUT_LENGTH = 2'd0;
    localparam logic [1:0] CFG_DERIVE_MODE   = 2'd1;

    localparam logic [LEN_W-1:0] OUTPUT_LENGTH_RESET = LEN_W'(32);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_OUT_BYTES);

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
    } req_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic [IDX_W-1:0] out_index;
        logic             last;
    } rsp_t;

    // Start of an output run, handed from the absorb unit to the emitter.
    typedef struct packed {
        logic             start;
        logic [31:0]      word;
        logic [LEN_W-1:0] len;
        logic             add7;
    } fin_t;

endpackage

[rtl/core/mkde_absorb.sv]
// Absorb unit: holds the mixing word and byte counts and folds them on finish.
module mkde_absorb
    import mkde_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  req_t             req,
    input  logic [LEN_W-1:0] output_length,
    input  logic             derive_mode,
    output fin_t             fin
);

    logic [31:0] mix_word_reg, mix_word_next;
    logic [31:0] key_count_reg, key_count_next;
    logic [31:0] context_count_reg, context_count_next;

    logic [31:0] key_word;
    logic [31:0] ctx_word;
    logic [31:0] key_prod;
    logic [31:0] ctx_prod;

    assign key_word = mix_word_reg ^ ({24'd0, req.data_byte} << {key_count_reg[1:0], 3'b000});
    assign ctx_word = mix_word_reg ^ ({24'd0, req.data_byte} << {context_count_reg[1:0], 3'b000});
    assign key_prod = key_word * FNV_PRIME;
    assign ctx_prod = ctx_word * MURMUR_MUL;

    always_comb
    begin
        mix_word_next      = mix_word_reg;
        key_count_next     = key_count_reg;
        context_count_next = context_count_reg;
        fin.start = 1'b0;
        fin.word  = mix_word_reg ^ (key_count_reg + context_count_reg);
        fin.len   = (output_length > MAX_LEN) ? MAX_LEN : output_length;
        fin.add7  = derive_mode;
        if (take)
        begin
            unique case (req.func)
                FUNC_KEY:
                begin
                    mix_word_next  = key_prod ^ (key_word >> 16);
                    key_count_next = key_count_reg + 32'd1;
                end
                FUNC_CONTEXT:
                begin
                    mix_word_next      = ctx_prod ^ ((ctx_word >> 13) + context_count_reg);
                    context_count_next = context_count_reg + 32'd1;
                end
                FUNC_FINISH:
                begin
                    fin.start          = 1'b1;
                    mix_word_next      = MIX_INIT;
                    key_count_next     = 32'd0;
                    context_count_next = 32'd0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_word_reg      <= MIX_INIT;
            key_count_reg     <= 32'd0;
            context_count_reg <= 32'd0;
        end
        else
        begin
            mix_word_reg      <= mix_word_next;
            key_count_reg     <= key_count_next;
            context_count_reg <= context_count_next;
        end
    end

endmodule

[rtl/core/mkde_emit.sv]
// Emitter: steps the folded word once per output byte into the result register.
module mkde_emit
    import mkde_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  fin_t fin,
    output logic busy,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    logic [31:0]      word_reg, word_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             add7_reg, add7_next;
    logic             active_reg, active_next;
    logic             valid_reg, valid_next;
    rsp_t             out_reg, out_next;

    logic             load;
    logic [LEN_W-1:0] idx_inc;
    logic [31:0]      prod;
    logic [31:0]      step_add;

    assign load     = active_reg && (!valid_reg || !rsp_stall);
    assign idx_inc  = idx_reg + LEN_W'(1);
    assign prod     = word_reg * MURMUR_MUL;
    assign step_add = {{(32-LEN_W){1'b0}}, idx_reg} + (add7_reg ? DERIVE_ADD : 32'd0);

    always_comb
    begin
        word_next   = word_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        add7_next   = add7_reg;
        active_next = active_reg;
        valid_next  = valid_reg && rsp_stall;
        out_next    = out_reg;
        if (fin.start)
        begin
            word_next   = fin.word;
            idx_next    = '0;
            len_next    = fin.len;
            add7_next   = fin.add7;
            active_next = (fin.len != '0);
        end
        else if (load)
        begin
            out_next.out_byte  = 8'(word_reg >> {idx_reg[1:0], 3'b000});
            out_next.out_index = idx_reg[IDX_W-1:0];
            out_next.last      = (idx_inc == len_reg);
            valid_next         = 1'b1;
            word_next          = prod ^ ((word_reg >> 13) + step_add);
            idx_next           = idx_inc;
            active_next        = (idx_inc != len_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        idx_reg  <= idx_next;
        len_reg  <= len_next;
        add7_reg <= add7_next;
        out_reg  <= out_next;
    end

    assign busy      = active_reg;
    assign rsp_valid = valid_reg;
    assign rsp_data  = out_reg;

endmodule

[rtl/core/mixing_key_derivation_engine.sv]
// Top level of the mixing key derivation engine: configuration and channel glue.
//
//   channel | signals                           | direction
//   --------+-----------------------------------+----------
//   request | req_valid, req_stall, req_data    | in
//   result  | rsp_valid, rsp_stall, rsp_data    | out
//   config  | cfg_valid, cfg_ready, cfg_index,  | in
//           | cfg_data                          |
//
// Key and context requests are taken one per cycle; each updates the word in that cycle.
// A finish request starts a run of up to 32 result bytes, one per unstalled cycle from
// the emitter, which steps its own word copy, so absorbs may continue during a run.
// A finish request is stalled while a previous run is still being emitted.
// Reset restores the initial word, clears both counts and loads default configuration.
module mixing_key_derivation_engine
    import mkde_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  req_t       req_data,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output rsp_t       rsp_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [5:0] cfg_data
);

    logic [LEN_W-1:0] output_length_reg, output_length_next;
    logic             derive_mode_reg, derive_mode_next;
    logic             busy;
    logic             take;
    fin_t             fin;

    assign cfg_ready = 1'b1;
    assign req_stall = busy && (req_data.func == FUNC_FINISH);
    assign take      = req_valid && !req_stall;

    always_comb
    begin
        output_length_next = output_length_reg;
        derive_mode_next   = derive_mode_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_OUTPUT_LENGTH: output_length_next = cfg_data[LEN_W-1:0];
                CFG_DERIVE_MODE:   derive_mode_next   = cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_length_reg <= OUTPUT_LENGTH_RESET;
            derive_mode_reg   <= 1'b1;
        end
        else
        begin
            output_length_reg <= output_length_next;
            derive_mode_reg   <= derive_mode_next;
        end
    end

    mkde_absorb u_absorb (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .req           (req_data),
        .output_length (output_length_reg),
        .derive_mode   (derive_mode_reg),
        .fin           (fin)
    );

    mkde_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .fin       (fin),
        .busy      (busy),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule
